// ===== hdl/sli_pkg.sv =====
`timescale 1ns / 1ps

package sli_pkg;

    // Operation selector carried on the input tuser.
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    // Outcome carried on the output tuser.
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_MISSING = 2'd2,
        STATUS_RANGE   = 2'd3
    } t_status;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned INDEX_W = 4;
    localparam int unsigned COUNT_W = 5;

    // Broadcast from the control to every cell of the row.
    typedef struct packed {
        logic                      ins_en;
        logic                      rem_en;
        logic signed [VALUE_W-1:0] value;
    } t_cell_ctl;

    // Compare flags that each cell reports.
    typedef struct packed {
        logic gt;
        logic ge;
        logic eq;
    } t_cell_flags;

endpackage

// ===== hdl/sli_cell.sv =====
`timescale 1ns / 1ps

module sli_cell (
    input  logic                               i_clk,
    input  sli_pkg::t_cell_ctl                 i_ctl,
    input  logic                               i_valid,
    input  logic                               i_sel,
    input  logic                               i_left_gt,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_left_entry,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_right_entry,
    output logic signed [sli_pkg::VALUE_W-1:0] o_entry,
    output sli_pkg::t_cell_flags               o_flags,
    output logic signed [sli_pkg::VALUE_W-1:0] o_rd_data
);
    import sli_pkg::*;

    logic signed [VALUE_W-1:0] r_entry;
    logic signed [VALUE_W-1:0] n_entry;

    // An empty slot counts as greater, so the first greater slot is the insert point.
    always_comb begin
        o_flags.gt = !i_valid || (r_entry > i_ctl.value);
        o_flags.ge = i_valid && (r_entry >= i_ctl.value);
        o_flags.eq = i_valid && (r_entry == i_ctl.value);
    end

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins_en && o_flags.gt) begin
            n_entry = i_left_gt ? i_left_entry : i_ctl.value;
        end else if (i_ctl.rem_en && o_flags.ge) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry   = r_entry;
    assign o_rd_data = (i_sel && i_valid) ? r_entry : '0;

endmodule

// ===== hdl/sorted_list_insert_remove.sv =====
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                 tuser        Handshake
// s side    in   value[31:0], index[35:32], pad 0   kind[1:0]    i_s_tvalid / o_s_tready
// m side    out  data[31:0], count[36:32], pad 0    status[1:0]  o_m_tvalid / i_m_tready
//
// For every item the compare-and-shift row of cells updates all
// entries at the transfer edge and the result lands in the output register.
// Throughput is one item per cycle while the output side keeps taking results;
// a held result blocks a new transfer only when i_m_tready is low.
// Reset (i_rst_n low, synchronous) empties the list and drops any held result;
// entry storage is not cleared, the fill count alone marks what is valid.

module sorted_list_insert_remove #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // value[31:0], index[35:32], zero pad
    input  logic [1:0]  i_s_tuser,   // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // data[31:0], count[36:32], zero pad
    output logic [1:0]  o_m_tuser    // status[1:0]
);
    import sli_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    // Unpack the incoming transfer.
    logic signed [VALUE_W-1:0] w_value;
    logic [INDEX_W-1:0]        w_index;
    t_kind                     w_kind;

    assign w_value = i_s_tdata[VALUE_W-1:0];
    assign w_index = i_s_tdata[VALUE_W+INDEX_W-1:VALUE_W];
    assign w_kind  = t_kind'(i_s_tuser);

    // List control state and output register.
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_out_valid;
    t_status                   r_status;
    t_status                   n_status;
    logic signed [VALUE_W-1:0] r_data;
    logic signed [VALUE_W-1:0] n_data;
    logic [COUNT_W-1:0]        r_res_count;

    logic w_accept;
    logic w_full;
    logic w_found;
    logic w_in_range;

    // Row wiring.
    t_cell_ctl                 w_ctl;
    logic signed [VALUE_W-1:0] w_entry   [CAPACITY];
    logic signed [VALUE_W-1:0] w_rd_data [CAPACITY];
    t_cell_flags               w_flags   [CAPACITY];
    logic [CAPACITY-1:0]       w_valid;
    logic [CAPACITY-1:0]       w_sel;
    logic [CAPACITY-1:0]       w_eq;
    logic [CAPACITY-1:0]       w_hit;
    logic signed [VALUE_W-1:0] w_rd_or;

    // Accept a new item whenever the output register is free or being emptied.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_found    = |w_eq;
    assign w_in_range = |w_hit;

    // Broadcast the operation; a remove shifts only when a match exists.
    assign w_ctl.ins_en = w_accept && (w_kind == KIND_INSERT) && !w_full;
    assign w_ctl.rem_en = w_accept && (w_kind == KIND_REMOVE) && w_found;
    assign w_ctl.value  = w_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_valid[g] = (r_count > CNT_W'(g));
        assign w_sel[g]   = (32'(w_index) == g);
        assign w_eq[g]    = w_flags[g].eq;
        assign w_hit[g]   = w_valid[g] && w_sel[g];

        logic                      w_left_gt;
        logic signed [VALUE_W-1:0] w_left_entry;
        logic signed [VALUE_W-1:0] w_right_entry;

        if (g == 0) begin : g_first
            // Nothing sits left of the head: it takes the new value directly.
            assign w_left_gt    = 1'b0;
            assign w_left_entry = w_entry[g];
        end else begin : g_mid
            assign w_left_gt    = w_flags[g-1].gt;
            assign w_left_entry = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            // The tail slot becomes empty on a remove; keep whatever it holds.
            assign w_right_entry = w_entry[g];
        end else begin : g_inner
            assign w_right_entry = w_entry[g+1];
        end

        sli_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_valid       (w_valid[g]),
            .i_sel         (w_sel[g]),
            .i_left_gt     (w_left_gt),
            .i_left_entry  (w_left_entry),
            .i_right_entry (w_right_entry),
            .o_entry       (w_entry[g]),
            .o_flags       (w_flags[g]),
            .o_rd_data     (w_rd_data[g])
        );
    end

    // Only the selected valid cell drives nonzero read data.
    always_comb begin
        w_rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd_or = w_rd_or | w_rd_data[i];
        end
    end

    // Result and next fill count for the item on the input.
    always_comb begin
        n_count  = r_count;
        n_status = STATUS_OK;
        n_data   = '0;
        unique case (w_kind)
            KIND_INSERT: begin
                if (w_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_REMOVE: begin
                if (w_found) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = STATUS_MISSING;
                end
            end
            KIND_READ: begin
                if (w_in_range) begin
                    n_data = w_rd_or;
                end else begin
                    n_status = STATUS_RANGE;
                end
            end
            default: begin
                // Unused kind: drop the item, report ok with the count as is.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_data      <= n_data;
            r_res_count <= COUNT_W'(n_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {3'b000, r_res_count, r_data};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_res_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_res_count == COUNT_W'(r_count)))
        else $error("reported count differs from list count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_kind == KIND_INSERT && !w_full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == STATUS_FULL) |-> w_full)
        else $error("full status with room left");

    a_remove_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_kind == KIND_REMOVE && w_found) |-> (r_count != '0))
        else $error("match found in an empty list");
`endif

endmodule

// ===== sim/sorted_list_insert_remove_tb.sv =====
`timescale 1ns / 1ps

module sorted_list_insert_remove_tb;

    import sli_pkg::*;

    localparam int unsigned CAPACITY    = 16;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned POOL_DEPTH  = 24;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        t_status              status;
        logic [VALUE_W-1:0]   data;
        logic [COUNT_W-1:0]   count;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;    // value[31:0], index[35:32], zero pad
    logic [1:0]  i_s_tuser;    // kind[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;    // data[31:0], count[36:32], zero pad
    logic [1:0]  o_m_tuser;    // status[1:0]

    // Shadow copy of the list, advanced at every accepted input transfer.
    logic signed [VALUE_W-1:0] list_entries [CAPACITY];
    int unsigned               list_count;

    t_outcome                  pending_outcomes [$];
    logic signed [VALUE_W-1:0] recent_values [$];

    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned hold_off_left;
    int unsigned stall_cycles;
    int unsigned error_count;
    int unsigned n_insert, n_remove, n_read, n_unused;
    int unsigned n_full, n_missing, n_range, n_results, max_fill;

    sorted_list_insert_remove #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Apply one operation to the shadow list and return the outcome it gives.
    function automatic t_outcome apply_operation(t_kind kind,
                                                 logic signed [VALUE_W-1:0] value,
                                                 logic [INDEX_W-1:0] index);
        t_outcome res;
        int       pos;
        int       i;
        bit       hit;
        res.status = STATUS_OK;
        res.data   = '0;
        hit        = 1'b0;
        case (kind)
            KIND_INSERT: begin
                if (list_count >= CAPACITY) begin
                    res.status = STATUS_FULL;
                end else begin
                    // New value goes after every equal entry.
                    pos = list_count;
                    for (i = 0; i < list_count; i++) begin
                        if (!hit && list_entries[i] > value) begin
                            pos = i;
                            hit = 1'b1;
                        end
                    end
                    for (i = list_count; i > pos; i--)
                        list_entries[i] = list_entries[i-1];
                    list_entries[pos] = value;
                    list_count++;
                end
            end
            KIND_REMOVE: begin
                for (i = 0; i < list_count; i++) begin
                    if (!hit && list_entries[i] == value)
                        hit = 1'b1;
                    if (hit && i + 1 < list_count)
                        list_entries[i] = list_entries[i+1];
                end
                if (hit)
                    list_count--;
                else
                    res.status = STATUS_MISSING;
            end
            KIND_READ: begin
                if (index < list_count)
                    res.data = list_entries[index];
                else
                    res.status = STATUS_RANGE;
            end
            default: ;
        endcase
        res.count = list_count[COUNT_W-1:0];
        return res;
    endfunction

    // Output ready: a long hold-off when requested, random stalls otherwise.
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_left > 0) begin
                i_m_tready <= 1'b0;
                hold_off_left--;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // Predict on each input transfer, check each output transfer, watch for hangs.
    always @(posedge i_clk) begin
        t_outcome exp_res;
        t_status  act_status;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                pending_outcomes.push_back(apply_operation(t_kind'(i_s_tuser),
                                                           i_s_tdata[31:0],
                                                           i_s_tdata[35:32]));
                case (t_kind'(i_s_tuser))
                    KIND_INSERT: n_insert++;
                    KIND_REMOVE: n_remove++;
                    KIND_READ:   n_read++;
                    default:     n_unused++;
                endcase
                if (list_count > max_fill)
                    max_fill = list_count;
            end
            if (o_m_tvalid && i_m_tready) begin
                act_status = t_status'(o_m_tuser);
                n_results++;
                case (act_status)
                    STATUS_FULL:    n_full++;
                    STATUS_MISSING: n_missing++;
                    STATUS_RANGE:   n_range++;
                    default: ;
                endcase
                if (pending_outcomes.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("ERROR: result with nothing expected: status %0d data %h count %0d",
                                 act_status, o_m_tdata[31:0], o_m_tdata[36:32]);
                end else begin
                    exp_res = pending_outcomes.pop_front();
                    if (act_status !== exp_res.status || o_m_tdata[31:0] !== exp_res.data ||
                        o_m_tdata[36:32] !== exp_res.count) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $write("ERROR: result %0d: expected status %0d data %h count %0d,",
                                   n_results, exp_res.status, exp_res.data, exp_res.count);
                            $display(" got status %0d data %h count %0d",
                                     act_status, o_m_tdata[31:0], o_m_tdata[36:32]);
                        end
                    end
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
                $display("FAIL sorted_list_insert_remove");
                $finish;
            end
        end
    end

    // Offer one item and hold it until the transfer edge.
    task automatic send_item(t_kind kind, logic signed [VALUE_W-1:0] value,
                             logic [INDEX_W-1:0] index);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, index, value};
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        if (kind == KIND_INSERT) begin
            recent_values.push_back(value);
            if (recent_values.size() > POOL_DEPTH)
                void'(recent_values.pop_front());
        end
    endtask

    // Drop valid right at the last transfer edge so nothing is taken twice.
    // Settle to the falling edge so the last prediction is queued before polling.
    task automatic wait_for_drain();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // Random operation; filling favors inserts, otherwise removes dominate.
    // Removes mostly hit values inserted lately so the list really shrinks.
    task automatic send_random_item(input bit filling, output bit counted);
        int unsigned               roll;
        int unsigned               ins_pct;
        t_kind                     kind;
        logic signed [VALUE_W-1:0] value;
        ins_pct = filling ? 60 : 15;
        roll    = $urandom_range(0, 99);
        if (roll < 4)
            kind = KIND_UNUSED;
        else if (roll < 4 + ins_pct)
            kind = KIND_INSERT;
        else if (roll < 79)
            kind = KIND_REMOVE;
        else
            kind = KIND_READ;
        roll  = $urandom_range(0, 99);
        value = $urandom;
        if (roll < 15) begin
            case ($urandom_range(0, 3))
                0: value = VAL_MAX;
                1: value = VAL_MIN;
                2: value = '0;
                default: value = -1;
            endcase
        end else if (roll < (kind == KIND_REMOVE ? 85 : 45) && recent_values.size() > 0) begin
            value = recent_values[$urandom_range(0, recent_values.size() - 1)];
        end
        send_item(kind, value, INDEX_W'($urandom_range(0, 15)));
        counted = (kind != KIND_UNUSED);
    endtask

    task automatic test_directed();
        int i;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // Empty list: read out of range, remove of an absent value, unused kind.
        send_item(KIND_READ,   '0,  4'd0);
        send_item(KIND_REMOVE, 7,   4'd0);
        send_item(KIND_UNUSED, -1,  4'd15);
        send_item(KIND_INSERT, VAL_MAX, 4'd0);
        send_item(KIND_INSERT, VAL_MIN, 4'd0);
        send_item(KIND_INSERT, '0,  4'd0);
        send_item(KIND_INSERT, '0,  4'd0);
        send_item(KIND_READ,   '0,  4'd1);
        send_item(KIND_READ,   '0,  4'd3);
        send_item(KIND_REMOVE, '0,  4'd0);
        send_item(KIND_REMOVE, 5,   4'd0);
        // Equal to the largest entry, then fill to capacity.
        send_item(KIND_INSERT, VAL_MAX, 4'd0);
        for (i = 0; i < 12; i++)
            send_item(KIND_INSERT, $urandom, 4'd0);
        send_item(KIND_INSERT, VAL_MAX, 4'd0);
        send_item(KIND_READ,   '0,  4'd15);
        send_item(KIND_UNUSED, VAL_MIN, 4'd0);
        // Last entry removed, then the top slot is out of range again.
        send_item(KIND_REMOVE, VAL_MAX, 4'd0);
        send_item(KIND_READ,   '0,  4'd15);
    endtask

    task automatic test_random_phase(int unsigned src_pct, int unsigned sink_pct,
                                     int unsigned n_items);
        int unsigned done;
        int unsigned issued;
        bit          counted;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        done           = 0;
        issued         = 0;
        while (done < n_items) begin
            send_random_item(((issued / 40) % 2) == 0, counted);
            issued++;
            if (counted)
                done++;
        end
    endtask

    // Output held off for a long stretch while the input keeps offering.
    task automatic test_backpressure();
        int i;
        bit counted;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_off_left  = HOLD_CYCLES;
        for (i = 0; i < 30; i++)
            send_random_item(1'b1, counted);
    endtask

    // Pause the input until every outstanding result is back, then resume.
    task automatic test_drain_pause();
        int i;
        bit counted;
        sink_stall_pct = 50;
        wait_for_drain();
        repeat (20) @(posedge i_clk);
        src_idle_pct = 30;
        for (i = 0; i < 20; i++)
            send_random_item(1'b0, counted);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_s_tvalid     <= 1'b0;
        i_s_tdata      <= '0;
        i_s_tuser      <= KIND_INSERT;
        list_count     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_off_left  = 0;
        stall_cycles   = 0;
        error_count    = 0;
        n_insert = 0; n_remove = 0; n_read = 0; n_unused = 0;
        n_full = 0; n_missing = 0; n_range = 0; n_results = 0; max_fill = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phase(0, 0, 250);
        test_random_phase(84, 0, 250);
        test_drain_pause();
        test_random_phase(0, 84, 250);
        test_backpressure();
        test_random_phase(15, 15, 250);

        wait_for_drain();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d inserts, %0d removes, %0d reads, %0d unused items; peak fill %0d",
                 n_insert, n_remove, n_read, n_unused, max_fill);
        $display("Checked %0d results: %0d full, %0d not found, %0d out of range; %0d errors",
                 n_results, n_full, n_missing, n_range, error_count);
        if (error_count == 0 && pending_outcomes.size() == 0) begin
            $display("PASS sorted_list_insert_remove");
        end else begin
            $display("FAIL sorted_list_insert_remove");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sli_pkg.sv
hdl/sli_cell.sv
hdl/sorted_list_insert_remove.sv
sim/sorted_list_insert_remove_tb.sv
